// File: rtl/ctmr_pkg.sv
// Shared types and constants for the column tolerant max reduction block.
// No dependencies; used by ctmr_term, the top level and ctmr_checker.
package ctmr_pkg;

    localparam int VAL_W   = 18;
    localparam int CFG_W   = 17;
    localparam int INDEX_W = 10;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 32;
    localparam int REG_W   = 2;

    localparam logic [REG_W-1:0] REG_EPSILON   = 2'd0;
    localparam logic [REG_W-1:0] REG_OFFSET    = 2'd1;
    localparam logic [REG_W-1:0] REG_TOL_FLOOR = 2'd2;

    localparam logic [CFG_W-1:0] EPSILON_RST   = 17'd655;
    localparam logic [CFG_W-1:0] OFFSET_RST    = 17'd0;
    localparam logic [CFG_W-1:0] TOL_FLOOR_RST = 17'd0;

    localparam logic signed [VAL_W-1:0] MOST_NEG = 18'sh20000;
    localparam logic signed [VAL_W:0]   ONE_Q16  = 19'sd65536;

    typedef struct packed {
        logic [CFG_W-1:0] epsilon;
        logic [CFG_W-1:0] target_offset;
        logic [CFG_W-1:0] tolerance_floor;
    } cfg_t;

endpackage

// File: rtl/column_tolerant_max_reduction.sv
// Top level: input register, row term and column max update, result register.
// Depends on ctmr_pkg and ctmr_term.
// Each column's last beat gives its result via the input register, then the result register.
// Throughput: one input beat per cycle unless a last beat waits for the result register.
// The result register frees the input side whenever it is empty or being taken.
// Reset (rst_n low, asynchronous): column state cleared, registers to 655 / 0 / 0.
module column_tolerant_max_reduction
#(
    parameter int MAX_COLUMNS = 1024
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ctmr_pkg::REG_W-1:0]  cfg_index,
    input  logic [ctmr_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ctmr_pkg::IN_W-1:0]   s_tdata,   // a_value[17:0], b_value[35:18], zero pad
    input  logic                        s_tlast,   // last_in_column
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ctmr_pkg::OUT_W-1:0]  m_tdata    // column_max[17:0], column_index[27:18], pad
);

    localparam int CNT_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_COLUMNS - 1);

    ctmr_pkg::cfg_t cfg_reg;

    logic                                in_valid_reg;
    logic signed [ctmr_pkg::VAL_W-1:0]   a_reg;
    logic signed [ctmr_pkg::VAL_W-1:0]   b_reg;
    logic                                last_reg;

    logic signed [ctmr_pkg::VAL_W-1:0]   max_reg;
    logic signed [ctmr_pkg::VAL_W-1:0]   max_next;
    logic                                stopped_reg;
    logic                                stopped_next;
    logic [CNT_W-1:0]                    col_reg;
    logic [CNT_W-1:0]                    col_next;

    logic                                out_valid_reg;
    logic signed [ctmr_pkg::VAL_W-1:0]   out_max_reg;
    logic [ctmr_pkg::INDEX_W-1:0]        out_index_reg;

    logic signed [ctmr_pkg::VAL_W-1:0]   term;
    logic signed [ctmr_pkg::VAL_W-1:0]   max_upd;
    logic signed [ctmr_pkg::VAL_W:0]     thresh;
    logic                                out_free;
    logic                                advance;
    logic                                in_take;
    logic [CNT_W+ctmr_pkg::INDEX_W-1:0]  col_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.epsilon         <= ctmr_pkg::EPSILON_RST;
            cfg_reg.target_offset   <= ctmr_pkg::OFFSET_RST;
            cfg_reg.tolerance_floor <= ctmr_pkg::TOL_FLOOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ctmr_pkg::REG_EPSILON:   cfg_reg.epsilon         <= cfg_data;
                ctmr_pkg::REG_OFFSET:    cfg_reg.target_offset   <= cfg_data;
                ctmr_pkg::REG_TOL_FLOOR: cfg_reg.tolerance_floor <= cfg_data;
                default:                 ;
            endcase
        end
    end

    ctmr_term u_term
    (
        .a_value (a_reg),
        .b_value (b_reg),
        .cfg     (cfg_reg),
        .term    (term)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign thresh  = ctmr_pkg::ONE_Q16 - $signed({2'b00, cfg_reg.epsilon});
    assign max_upd = stopped_reg ? max_reg : ((term > max_reg) ? term : max_reg);
    assign col_ext = {{ctmr_pkg::INDEX_W{1'b0}}, col_reg};

    always_comb
    begin
        max_next     = max_reg;
        stopped_next = stopped_reg;
        col_next     = col_reg;
        if (advance)
        begin
            if (last_reg)
            begin
                max_next     = ctmr_pkg::MOST_NEG;
                stopped_next = 1'b0;
                col_next     = (col_reg == CNT_LAST) ? '0 : col_reg + 1'b1;
            end
            else
            begin
                max_next     = max_upd;
                stopped_next = stopped_reg || ($signed({max_upd[17], max_upd}) > thresh);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            max_reg       <= ctmr_pkg::MOST_NEG;
            stopped_reg   <= 1'b0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            max_reg     <= max_next;
            stopped_reg <= stopped_next;
            col_reg     <= col_next;
            if (out_free)
            begin
                out_valid_reg <= advance && last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_reg    <= s_tdata[17:0];
            b_reg    <= s_tdata[35:18];
            last_reg <= s_tlast;
        end
        if (advance && last_reg)
        begin
            out_max_reg   <= max_upd;
            out_index_reg <= col_ext[ctmr_pkg::INDEX_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_index_reg, out_max_reg};

endmodule

// File: rtl/ctmr_term.sv
// Row term: offset and clip the target, form the tolerance, pick the term.
// Depends on ctmr_pkg.
module ctmr_term
(
    input  logic signed [ctmr_pkg::VAL_W-1:0] a_value,
    input  logic signed [ctmr_pkg::VAL_W-1:0] b_value,
    input  ctmr_pkg::cfg_t                    cfg,
    output logic signed [ctmr_pkg::VAL_W-1:0] term
);

    logic signed [18:0] b_off;
    logic [16:0]        b_clip;
    logic [17:0]        a_u;
    logic [17:0]        a_mag;
    logic [17:0]        mag;
    logic [34:0]        prod;
    logic [18:0]        tol_prod;
    logic [18:0]        tol;
    logic signed [18:0] diff_s;
    logic [18:0]        diff;
    logic               near;

    assign b_off    = $signed({b_value[17], b_value}) - $signed({2'b00, cfg.target_offset});
    assign b_clip   = b_off[18] ? 17'd0 : b_off[16:0];
    assign a_u      = a_value;
    assign a_mag    = a_value[17] ? (~a_u + 18'd1) : a_u;
    assign mag      = (a_mag > {1'b0, b_clip}) ? a_mag : {1'b0, b_clip};
    assign prod     = 35'(mag) * 35'(cfg.epsilon);
    assign tol_prod = prod[34:16];
    assign tol      = (tol_prod < {2'b00, cfg.tolerance_floor})
                      ? {2'b00, cfg.tolerance_floor} : tol_prod;
    assign diff_s   = $signed({a_value[17], a_value}) - $signed({2'b00, b_clip});
    assign diff     = diff_s[18] ? (~diff_s + 19'sd1) : diff_s;
    assign near     = (diff <= tol);
    assign term     = (!near && diff_s[18]) ? $signed({1'b0, b_clip}) : 18'sd0;

endmodule

// File: rtl/ctmr_checker.sv
// Port-level checks for column_tolerant_max_reduction, bound to the top level.
// Depends on ctmr_pkg.
module ctmr_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [ctmr_pkg::OUT_W-1:0]  m_tdata
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // every column max takes in at least one term, and no term is negative, so the max is never negative
    a_max_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[ctmr_pkg::VAL_W-1])
        else $error("negative column max");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[ctmr_pkg::OUT_W-1:28] == 4'd0)
        else $error("pad bits set");

    // an empty result register never blocks the input side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_tvalid)
        else $error("result beat right after reset");

endmodule

bind column_tolerant_max_reduction ctmr_checker u_ctmr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
